### src/streaming_kth_largest_tracker_assert.svh
// Assertion macros for the checker of the k-th largest tracker.
// The macros expect clk in scope, and all but SKL_ASSERT_RST also rst_n.
`ifndef STREAMING_KTH_LARGEST_TRACKER_ASSERT_SVH
`define STREAMING_KTH_LARGEST_TRACKER_ASSERT_SVH

// Overlapping implication, off while reset is held.
`define SKL_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is held.
`define SKL_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

// Next-cycle implication that stays on during reset.
`define SKL_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

### src/skl_pkg.sv
// Shared constants and types of the streaming k-th largest tracker.
// No dependencies; used by the cell, group and top-level modules.
package skl_pkg;

  localparam int MAX_K    = 64;
  localparam int VALUE_W  = 32;
  localparam int RANK_W   = 7;
  // Count holds up to MAX_K + 1 before it is clamped to the rank.
  localparam int CNT_W    = $clog2(MAX_K + 2);
  localparam int CMP_W    = (CNT_W > RANK_W) ? CNT_W : RANK_W;
  localparam int GRP_SIZE = 8;
  localparam int NUM_GRP  = (MAX_K + GRP_SIZE - 1) / GRP_SIZE;
  localparam int CELLS_PAD = NUM_GRP * GRP_SIZE;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic [CNT_W-1:0]          count_t;

  // What a cell hands to its right-hand neighbor.
  typedef struct packed {
    logic   ge;
    value_t value;
  } link_t;

  // Per-cell control decoded from the occupancy count.
  typedef struct packed {
    logic occupied;
    logic tail;
  } cell_ctl_t;

endpackage

### src/skl_cell.sv
// One storage cell of the sorted insertion chain.
// Depends on skl_pkg.
module skl_cell import skl_pkg::*; (
  input  logic      clk,
  input  logic      upd,
  input  value_t    sample,
  input  cell_ctl_t ctl,
  input  link_t     left_link,
  output link_t     right_link,
  output value_t    tap
);

  value_t value_r;
  value_t value_nxt;
  logic   ge;

  // Entries at or above the new sample stay put; the first one below it takes
  // the sample and every later one takes its left neighbor's old value.
  assign ge = ctl.occupied && (value_r >= sample);

  always_comb begin
    if (ge) begin
      value_nxt = value_r;
    end else if (left_link.ge) begin
      value_nxt = sample;
    end else begin
      value_nxt = left_link.value;
    end
  end

  always_ff @(posedge clk) begin
    if (upd) begin
      value_r <= value_nxt;
    end
  end

  assign right_link.ge    = ge;
  assign right_link.value = value_r;
  assign tap              = ctl.tail ? value_nxt : '0;

endmodule

### src/skl_group.sv
// Registered OR stage that merges the taps of one group of cells.
// Depends on skl_pkg. At most one tap in the whole chain is nonzero-selected.
module skl_group import skl_pkg::*; (
  input  logic                             clk,
  input  logic                             load,
  input  logic [GRP_SIZE-1:0][VALUE_W-1:0] taps,
  output value_t                           merged_r
);

  value_t merged_nxt;

  always_comb begin
    merged_nxt = '0;
    for (int i = 0; i < GRP_SIZE; i++) begin
      merged_nxt = merged_nxt | value_t'(taps[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      merged_r <= merged_nxt;
    end
  end

endmodule

### src/streaming_kth_largest_tracker.sv
// Top level of the streaming k-th largest tracker.
// Depends on skl_pkg, skl_cell and skl_group.
//
// Usage:
// The input channel (in_valid, in_stall, in_sample_value) carries one signed
// 32-bit sample per word. Every accepted word produces exactly one result word
// on the output channel (out_valid, out_stall, out_kth_value, out_rank_filled).
// The result is the smallest of the retained largest values, which is the k-th
// largest seen once k values are held; out_rank_filled tells whether that is so.
// The rank k is written through cfg_wr_en / cfg_wr_data while the block is idle.
// A rank of zero acts as one and a rank above MAX_K acts as MAX_K.
// Throughput is one word per cycle while the receiver does not stall: the
// whole chain of cells compares against the new sample in parallel and
// updates in the cycle the word is accepted. The accepting edge updates the
// cell chain and loads the group merge registers (stage A); the final merge
// then moves into the output register (stage B) once that register is free.
// Reset clears the retained count and sets the rank to one; the cell contents
// are not cleared because only counted entries are ever read.
// When the receiver stalls, the result holds, and the block keeps accepting
// until the merge stage is also full; in_stall then follows out_stall.
module streaming_kth_largest_tracker import skl_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [31:0] in_sample_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_kth_value,
  output logic               out_rank_filled,
  input  logic               cfg_wr_en,
  input  logic [6:0]         cfg_wr_data
);

  // Configuration: the rank is clamped to 1..MAX_K as it is written, so the
  // datapath only ever sees the effective rank.
  count_t           k_eff_r;
  count_t           k_eff_nxt;
  logic [CMP_W-1:0] rank_ext;

  assign rank_ext = CMP_W'(cfg_wr_data);

  always_comb begin
    if (rank_ext == '0) begin
      k_eff_nxt = CNT_W'(1);
    end else if (rank_ext > CMP_W'(MAX_K)) begin
      k_eff_nxt = CNT_W'(MAX_K);
    end else begin
      k_eff_nxt = CNT_W'(rank_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_eff_r <= CNT_W'(1);
    end else if (cfg_wr_en) begin
      k_eff_r <= k_eff_nxt;
    end
  end

  // Handshake and pipeline control. Stage A is the group merge registers,
  // stage B the output register.
  logic a_valid_r;
  logic a_valid_nxt;
  logic a_filled_r;
  logic a_ready;
  logic b_ready;
  logic b_load;
  logic in_accept;
  logic out_valid_r;
  logic out_valid_nxt;

  assign b_ready   = !out_valid_r || !out_stall;
  assign b_load    = a_valid_r && b_ready;
  assign a_ready   = !a_valid_r || b_ready;
  assign in_accept = in_valid && a_ready;
  assign in_stall  = !a_ready;

  always_comb begin
    if (in_accept) begin
      a_valid_nxt = 1'b1;
    end else if (b_load) begin
      a_valid_nxt = 1'b0;
    end else begin
      a_valid_nxt = a_valid_r;
    end
  end

  always_comb begin
    if (b_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  // Retained count. The new count is the old one plus one, capped by the rank;
  // a lowered rank thus trims the chain on the next insertion.
  count_t count_r;
  count_t count_inc;
  count_t count_nxt;

  assign count_inc = count_r + CNT_W'(1);
  assign count_nxt = (count_inc > k_eff_r) ? k_eff_r : count_inc;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      a_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        count_r <= count_nxt;
      end
      a_valid_r   <= a_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_filled_r <= (count_nxt == k_eff_r);
    end
  end

  // Cell chain, sorted from largest (cell 0) to smallest. Each cell learns
  // from the count whether it holds a live entry and whether it becomes the
  // new tail, whose updated value is the result.
  link_t                             links [MAX_K+1];
  logic [CELLS_PAD-1:0][VALUE_W-1:0] taps;

  assign links[0] = '{ge: 1'b1, value: '0};

  for (genvar j = 0; j < CELLS_PAD; j++) begin : g_cell
    if (j < MAX_K) begin : g_live
      cell_ctl_t ctl;
      value_t    tap;

      assign ctl.occupied = (CNT_W'(j) < count_r);
      assign ctl.tail     = (CNT_W'(j + 1) == count_nxt);

      skl_cell u_cell (
        .clk        (clk),
        .upd        (in_accept),
        .sample     (in_sample_value),
        .ctl        (ctl),
        .left_link  (links[j]),
        .right_link (links[j+1]),
        .tap        (tap)
      );

      assign taps[j] = tap;
    end else begin : g_pad
      assign taps[j] = '0;
    end
  end

  // Two-level merge of the tail value: groups into stage A, then stage B.
  value_t grp_merged [NUM_GRP];

  for (genvar g = 0; g < NUM_GRP; g++) begin : g_grp
    skl_group u_group (
      .clk      (clk),
      .load     (in_accept),
      .taps     (taps[g*GRP_SIZE +: GRP_SIZE]),
      .merged_r (grp_merged[g])
    );
  end

  value_t final_merged;
  value_t out_kth_value_r;
  logic   out_rank_filled_r;

  always_comb begin
    final_merged = '0;
    for (int g = 0; g < NUM_GRP; g++) begin
      final_merged = final_merged | grp_merged[g];
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      out_kth_value_r   <= final_merged;
      out_rank_filled_r <= a_filled_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kth_value   = out_kth_value_r;
  assign out_rank_filled = out_rank_filled_r;

endmodule

### src/skl_checker.sv
// Port-level checker for the streaming k-th largest tracker, with its bind.
// Depends on streaming_kth_largest_tracker_assert.svh.
`include "streaming_kth_largest_tracker_assert.svh"

module skl_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [31:0] out_kth_value,
  input logic               out_rank_filled
);

  logic        in_take;
  logic        out_wait;
  logic [32:0] out_word;

  assign in_take  = in_valid && !in_stall;
  assign out_wait = out_valid && out_stall;
  assign out_word = {out_kth_value, out_rank_filled};

  `SKL_ASSERT_RST(a_reset_empty, !rst_n, !out_valid, "output word valid after reset")
  `SKL_ASSERT_NXT(a_hold, out_wait, out_valid && $stable(out_word), "stalled output word changed")
  `SKL_ASSERT_IMP(a_no_stall_when_empty, !out_valid, !in_stall, "input stalled with empty output")
  `SKL_ASSERT_IMP(a_latency, $rose(out_valid), $past(in_take, 2), "result without an accepted word")

endmodule

bind streaming_kth_largest_tracker skl_checker u_skl_checker (.*);
